// ===== design/frtt_pkg.sv =====
// frtt_pkg: widths, register map constants, command codes and FSM state
// type for the FM register to tone translator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package frtt_pkg;

  // Channel count and derived index width
  localparam int unsigned CHANNELS = 9;
  localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths
  localparam int unsigned CH_W   = 4;
  localparam int unsigned ADDR_W = 8;
  localparam int unsigned VAL_W  = 8;
  localparam int unsigned MASK_W = 9;
  localparam int unsigned TC_W   = 20;
  localparam int unsigned PER_W  = 12;
  localparam int unsigned VOL_W  = 4;
  localparam int unsigned LVL_W  = 6;
  localparam int unsigned BLK_W  = 3;
  localparam int unsigned CMD_W  = 2;

  // Pitch arithmetic widths
  localparam int unsigned FNUM_W    = 10;
  localparam int unsigned PROD_W    = 26;
  localparam int unsigned HZ_W      = 13;
  localparam int unsigned SH_W      = 5;
  localparam int unsigned MUL_CNT_W = $clog2(FNUM_W + 1);
  localparam int unsigned DIV_CNT_W = $clog2(PER_W + 1);
  localparam int unsigned REM_INIT_W = TC_W - PER_W;

  // Constants of the register map and pitch formula
  localparam logic [15:0]       FM_CONST       = 16'd49716;
  localparam logic [PER_W-1:0]  PERIOD_MAX     = 12'hFFF;
  localparam int unsigned       KEYON_POS      = 5;
  localparam logic [LVL_W-1:0]  LEVEL_MASK     = 6'h3F;
  localparam logic [ADDR_W-1:0] ADDR_LEVEL     = 8'h40;
  localparam logic [ADDR_W-1:0] ADDR_FLO       = 8'hA0;
  localparam logic [ADDR_W-1:0] ADDR_FHI       = 8'hB0;
  localparam logic [ADDR_W-1:0] LEVEL_SPAN     = 8'h16;
  localparam logic [SH_W-1:0]   SHIFT_BASE     = 5'd20;
  localparam logic [TC_W-1:0]   TONE_CLOCK_RST = 20'd125000;
  localparam logic [VOL_W-1:0]  VOL_FULL       = 4'hF;

  // Output command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_NONE = 2'd0,
    CMD_OFF  = 2'd1,
    CMD_ON   = 2'd2,
    CMD_SET  = 2'd3
  } cmd_t;

  // Sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EVAL,
    ST_MUL,
    ST_PITCH,
    ST_DIV,
    ST_EMIT,
    ST_SWEEP
  } state_t;

endpackage

`default_nettype wire

// ===== design/frtt_if.sv =====
// frtt_if: valid/ready channel interfaces for register writes in, tone
// commands out, and the tone clock write port. Depends on frtt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface frtt_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [frtt_pkg::ADDR_W-1:0] reg_address;
  logic [frtt_pkg::VAL_W-1:0]  reg_value;
  logic [frtt_pkg::MASK_W-1:0] tone_active_mask;

  modport source (output valid, mode, reg_address, reg_value, tone_active_mask,
                  input ready);
  modport sink (input valid, mode, reg_address, reg_value, tone_active_mask,
                output ready);
endinterface

interface frtt_out_if;
  logic                       valid;
  logic                       ready;
  logic [frtt_pkg::CMD_W-1:0] command;
  logic [frtt_pkg::CH_W-1:0]  channel;
  logic [frtt_pkg::PER_W-1:0] period;
  logic [frtt_pkg::VOL_W-1:0] volume;
  logic                       last;

  modport source (output valid, command, channel, period, volume, last,
                  input ready);
  modport sink (input valid, command, channel, period, volume, last,
                output ready);
endinterface

interface frtt_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [frtt_pkg::TC_W-1:0] tone_clock;

  modport source (output valid, tone_clock, input ready);
  modport sink (input valid, tone_clock, output ready);
endinterface

`default_nettype wire

// ===== design/frtt_serial_mul.sv =====
// frtt_serial_mul: bit-serial shift-add multiplier, F-number times the FM
// pitch constant, one F-number bit per cycle, MSB first. Depends on frtt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frtt_serial_mul (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [frtt_pkg::FNUM_W-1:0]   fnum,
  output logic      [frtt_pkg::PROD_W-1:0]   product,
  output logic                               done
);

  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [frtt_pkg::MUL_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [frtt_pkg::FNUM_W-1:0]      mplier_r, mplier_nxt;
  logic [frtt_pkg::PROD_W-1:0]      acc_r, acc_nxt;
  logic [frtt_pkg::PROD_W-1:0]      addend;

  // Add the constant when the current F-number bit is set
  assign addend = mplier_r[frtt_pkg::FNUM_W-1] ?
                  frtt_pkg::PROD_W'(frtt_pkg::FM_CONST) : '0;

  // Load on start, then shift-add one bit per cycle
  always_comb begin
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    done_nxt   = 1'b0;
    if (start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = frtt_pkg::MUL_CNT_W'(frtt_pkg::FNUM_W);
      mplier_nxt = fnum;
      acc_nxt    = '0;
    end else if (busy_r) begin
      acc_nxt    = {acc_r[frtt_pkg::PROD_W-2:0], 1'b0} + addend;
      mplier_nxt = {mplier_r[frtt_pkg::FNUM_W-2:0], 1'b0};
      cnt_nxt    = cnt_r - 1'b1;
      if (cnt_r == frtt_pkg::MUL_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
  end

  assign product = acc_r;
  assign done    = done_r;

endmodule

`default_nettype wire

// ===== design/frtt_serial_div.sv =====
// frtt_serial_div: restoring divider, one quotient bit per cycle, for the
// tone clock over the pitch when the period fits 12 bits. Depends on frtt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frtt_serial_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [frtt_pkg::TC_W-1:0]   dividend,
  input  wire logic [frtt_pkg::HZ_W-1:0]   divisor,
  output logic      [frtt_pkg::PER_W-1:0]  quotient,
  output logic                             done
);

  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [frtt_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [frtt_pkg::HZ_W-1:0]        rem_r, rem_nxt;
  logic [frtt_pkg::HZ_W-1:0]        dvs_r, dvs_nxt;
  logic [frtt_pkg::PER_W-1:0]       num_r, num_nxt;
  logic [frtt_pkg::PER_W-1:0]       quo_r, quo_nxt;
  logic [frtt_pkg::HZ_W:0]          trial;
  logic                             fits;

  // Bring down the next dividend bit and try the subtract
  assign trial = {rem_r, num_r[frtt_pkg::PER_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  // Upper dividend bits seed the remainder; caller guarantees they are below divisor
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = frtt_pkg::DIV_CNT_W'(frtt_pkg::PER_W);
      rem_nxt  = frtt_pkg::HZ_W'(dividend[frtt_pkg::TC_W-1:frtt_pkg::PER_W]);
      num_nxt  = dividend[frtt_pkg::PER_W-1:0];
      dvs_nxt  = divisor;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? frtt_pkg::HZ_W'(trial - {1'b0, dvs_r})
                     : trial[frtt_pkg::HZ_W-1:0];
      quo_nxt = {quo_r[frtt_pkg::PER_W-2:0], fits};
      num_nxt = {num_r[frtt_pkg::PER_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == frtt_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

// ===== design/fm_register_to_tone_translator_unit.sv =====
// fm_register_to_tone_translator_unit: top level. Shadow registers, decode
// sequencer and output register. Depends on frtt_pkg, frtt_if,
// frtt_serial_mul and frtt_serial_div.
`timescale 1ns / 1ps
`default_nettype none

// Translates FM synthesizer register writes into square-tone commands. One
// input transaction is handled at a time. A write that produces no command
// frees the input straight after decode. A key-off command for a write that
// clears key-on passes the decode, evaluate and emit states before it is loaded
// into the output register. A key-on or set command runs the pitch through the
// serial multiplier (one F-number bit at a time) and, when the pitch is at least
// 2 and the period does not saturate, the serial divider (one period bit at a
// time). A reset transaction clears every shadow at once and then delivers one
// key-off per channel, one per cycle while the output takes them. Results wait
// in an output register, so the next transaction is taken while a result is
// still pending. The tone clock write port is always ready; write it only while the block is idle.
module fm_register_to_tone_translator_unit (
  input  wire logic    clk,
  input  wire logic    rst_n,
  frtt_in_if.sink      in_ch,
  frtt_out_if.source   out_ch,
  frtt_cfg_if.sink     cfg_ch
);

  localparam int unsigned CH_IDX_W = frtt_pkg::CH_IDX_W;
  localparam int unsigned CH_W     = frtt_pkg::CH_W;
  localparam logic [frtt_pkg::ADDR_W-1:0] CH_COUNT_A =
    frtt_pkg::ADDR_W'(frtt_pkg::CHANNELS);
  localparam logic [CH_W-1:0] CH_COUNT = CH_W'(frtt_pkg::CHANNELS);
  localparam logic [CH_W-1:0] CH_LAST  = CH_W'(frtt_pkg::CHANNELS - 1);

  // Sequencer
  frtt_pkg::state_t state_r, state_nxt;

  // Held transaction
  logic                          mode_r;
  logic [frtt_pkg::ADDR_W-1:0]   addr_r;
  logic [frtt_pkg::VAL_W-1:0]    val_r;
  logic [frtt_pkg::MASK_W-1:0]   mask_r;

  // Shadow registers
  logic [frtt_pkg::VAL_W-1:0]    flo_r [frtt_pkg::CHANNELS];
  logic [frtt_pkg::VAL_W-1:0]    fhi_r [frtt_pkg::CHANNELS];
  logic [frtt_pkg::LVL_W-1:0]    lvl_r [frtt_pkg::CHANNELS];

  // Result under construction
  logic [CH_W-1:0]               ch_r, ch_nxt;
  frtt_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [frtt_pkg::PER_W-1:0]    per_r, per_nxt;
  logic [frtt_pkg::VOL_W-1:0]    vol_r, vol_nxt;

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  frtt_pkg::cmd_t                out_cmd_r;
  logic [CH_W-1:0]               out_ch_r;
  logic [frtt_pkg::PER_W-1:0]    out_per_r;
  logic [frtt_pkg::VOL_W-1:0]    out_vol_r;
  logic                          out_last_r;

  logic [frtt_pkg::TC_W-1:0]     tone_clock_r;

  // Sequencer outputs
  logic                          in_ready;
  logic                          mul_start;
  logic                          div_start;
  logic                          out_load;
  logic                          out_free;
  logic                          in_acc;

  // Decode
  logic [frtt_pkg::ADDR_W-1:0]   flo_off, fhi_off, lvl_off;
  logic                          flo_hit, fhi_hit, lvl_hit, any_hit;
  logic [2:0]                    col;
  logic [CH_W-1:0]               grp;
  logic [CH_W-1:0]               lvl_ch;
  logic [CH_W-1:0]               dec_ch;
  logic [CH_IDX_W-1:0]           dec_idx;
  logic                          same, in_sync, drop, dec_write, dec_eval;

  // Evaluation
  logic [CH_IDX_W-1:0]           ch_idx;
  logic [frtt_pkg::VAL_W-1:0]    cur_hi;
  logic [frtt_pkg::VOL_W-1:0]    cur_vol;
  logic [frtt_pkg::BLK_W-1:0]    cur_blk;
  logic                          cur_active;
  frtt_pkg::cmd_t                on_cmd;
  logic [frtt_pkg::PROD_W-1:0]   product;
  logic                          mul_done;
  logic [frtt_pkg::PROD_W-1:0]   prod_sh;
  logic [frtt_pkg::HZ_W-1:0]     hz;
  logic                          hz_low, sat;
  logic [frtt_pkg::PER_W-1:0]    quotient;
  logic                          div_done;

  assign in_acc   = in_ch.valid & in_ready;
  assign out_free = ~out_valid_r | out_ch.ready;

  // Address decode of the held write
  always_comb begin
    flo_off = addr_r - frtt_pkg::ADDR_FLO;
    fhi_off = addr_r - frtt_pkg::ADDR_FHI;
    lvl_off = addr_r - frtt_pkg::ADDR_LEVEL;
    col     = lvl_off[2:0];
    grp     = CH_W'(lvl_off[4:3]);
    lvl_ch  = (grp << 1) + grp + CH_W'(col) - CH_W'(3);
    flo_hit = (flo_off < CH_COUNT_A);
    fhi_hit = (fhi_off < CH_COUNT_A);
    lvl_hit = (lvl_off < frtt_pkg::LEVEL_SPAN) && (col >= 3'd3) && (col <= 3'd5) &&
              (lvl_ch < CH_COUNT);
    any_hit = flo_hit | fhi_hit | lvl_hit;
    priority if (flo_hit) begin
      dec_ch = CH_W'(flo_off);
    end else if (fhi_hit) begin
      dec_ch = CH_W'(fhi_off);
    end else begin
      dec_ch = lvl_ch;
    end
    dec_idx = dec_ch[CH_IDX_W-1:0];
  end

  // Drop a write that matches its shadow while the device agrees with key-on
  always_comb begin
    priority if (flo_hit) begin
      same = (flo_r[dec_idx] == val_r);
    end else if (fhi_hit) begin
      same = (fhi_r[dec_idx] == val_r);
    end else begin
      same = (lvl_r[dec_idx] == (val_r[frtt_pkg::LVL_W-1:0] & frtt_pkg::LEVEL_MASK));
    end
    in_sync   = (mask_r[dec_ch] == fhi_r[dec_idx][frtt_pkg::KEYON_POS]);
    drop      = same & in_sync;
    dec_write = ~mode_r & any_hit & ~drop;
    dec_eval  = dec_write & (fhi_hit | fhi_r[dec_idx][frtt_pkg::KEYON_POS]);
  end

  // Shadow fields of the channel being evaluated
  assign ch_idx     = ch_r[CH_IDX_W-1:0];
  assign cur_hi     = fhi_r[ch_idx];
  assign cur_vol    = frtt_pkg::VOL_FULL - lvl_r[ch_idx][frtt_pkg::LVL_W-1:2];
  assign cur_blk    = cur_hi[4:2];
  assign cur_active = mask_r[ch_r];
  assign on_cmd     = cur_active ? frtt_pkg::CMD_SET : frtt_pkg::CMD_ON;

  // Pitch from the product; saturate when tone_clock / pitch exceeds 12 bits
  assign prod_sh = product >> (frtt_pkg::SHIFT_BASE - frtt_pkg::SH_W'(cur_blk));
  assign hz      = prod_sh[frtt_pkg::HZ_W-1:0];
  assign hz_low  = (hz < frtt_pkg::HZ_W'(2));
  assign sat     = (frtt_pkg::HZ_W'(tone_clock_r[frtt_pkg::TC_W-1:frtt_pkg::PER_W]) >= hz);

  frtt_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .fnum    ({cur_hi[1:0], flo_r[ch_idx]}),
    .product (product),
    .done    (mul_done)
  );

  frtt_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (tone_clock_r),
    .divisor  (hz),
    .quotient (quotient),
    .done     (div_done)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      frtt_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = frtt_pkg::ST_DECODE;
        end
      end
      frtt_pkg::ST_DECODE: begin
        priority if (mode_r) begin
          state_nxt = frtt_pkg::ST_SWEEP;
        end else if (dec_eval) begin
          state_nxt = frtt_pkg::ST_EVAL;
        end else begin
          state_nxt = frtt_pkg::ST_IDLE;
        end
      end
      frtt_pkg::ST_EVAL: begin
        if (!cur_hi[frtt_pkg::KEYON_POS] || cur_vol == '0) begin
          state_nxt = frtt_pkg::ST_EMIT;
        end else begin
          state_nxt = frtt_pkg::ST_MUL;
        end
      end
      frtt_pkg::ST_MUL: begin
        if (mul_done) begin
          state_nxt = frtt_pkg::ST_PITCH;
        end
      end
      frtt_pkg::ST_PITCH: begin
        if (hz_low || sat) begin
          state_nxt = frtt_pkg::ST_EMIT;
        end else begin
          state_nxt = frtt_pkg::ST_DIV;
        end
      end
      frtt_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = frtt_pkg::ST_EMIT;
        end
      end
      frtt_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = frtt_pkg::ST_IDLE;
        end
      end
      frtt_pkg::ST_SWEEP: begin
        if (out_free && ch_r == CH_LAST) begin
          state_nxt = frtt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = frtt_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      frtt_pkg::ST_IDLE:  in_ready  = 1'b1;
      frtt_pkg::ST_EVAL:  mul_start = cur_hi[frtt_pkg::KEYON_POS] & (cur_vol != '0);
      frtt_pkg::ST_PITCH: div_start = ~hz_low & ~sat;
      frtt_pkg::ST_EMIT:  out_load  = out_free;
      frtt_pkg::ST_SWEEP: out_load  = out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Build the pending result
  always_comb begin
    ch_nxt  = ch_r;
    cmd_nxt = cmd_r;
    per_nxt = per_r;
    vol_nxt = vol_r;
    unique case (state_r)
      frtt_pkg::ST_DECODE: begin
        ch_nxt  = mode_r ? '0 : dec_ch;
        cmd_nxt = frtt_pkg::CMD_OFF;
      end
      frtt_pkg::ST_EVAL: begin
        vol_nxt = cur_vol;
        cmd_nxt = frtt_pkg::CMD_OFF;
      end
      frtt_pkg::ST_PITCH: begin
        if (hz_low) begin
          cmd_nxt = frtt_pkg::CMD_OFF;
        end else if (sat) begin
          cmd_nxt = on_cmd;
          per_nxt = frtt_pkg::PERIOD_MAX;
        end
      end
      frtt_pkg::ST_DIV: begin
        if (div_done) begin
          per_nxt = quotient;
          cmd_nxt = (quotient == '0) ? frtt_pkg::CMD_OFF : on_cmd;
        end
      end
      frtt_pkg::ST_SWEEP: begin
        if (out_free && ch_r != CH_LAST) begin
          ch_nxt = ch_r + 1'b1;
        end
      end
      default: begin
        ch_nxt = ch_r;
      end
    endcase
  end

  // Output register holds until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= frtt_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      tone_clock_r <= frtt_pkg::TONE_CLOCK_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        tone_clock_r <= cfg_ch.tone_clock;
      end
    end
  end

  // Shadow registers: clear on reset or a reset transaction, write on decode
  always_ff @(posedge clk) begin
    if (!rst_n || (state_r == frtt_pkg::ST_DECODE && mode_r)) begin
      for (int i = 0; i < frtt_pkg::CHANNELS; i++) begin
        flo_r[i] <= '0;
        fhi_r[i] <= '0;
        lvl_r[i] <= '0;
      end
    end else if (state_r == frtt_pkg::ST_DECODE && dec_write) begin
      priority if (flo_hit) begin
        flo_r[dec_idx] <= val_r;
      end else if (fhi_hit) begin
        fhi_r[dec_idx] <= val_r;
      end else begin
        lvl_r[dec_idx] <= val_r[frtt_pkg::LVL_W-1:0] & frtt_pkg::LEVEL_MASK;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_ch.mode;
      addr_r <= in_ch.reg_address;
      val_r  <= in_ch.reg_value;
      mask_r <= in_ch.tone_active_mask;
    end
    ch_r  <= ch_nxt;
    cmd_r <= cmd_nxt;
    per_r <= per_nxt;
    vol_r <= vol_nxt;
    if (out_load) begin
      out_ch_r <= ch_r;
      if (state_r == frtt_pkg::ST_SWEEP) begin
        out_cmd_r  <= frtt_pkg::CMD_OFF;
        out_per_r  <= '0;
        out_vol_r  <= '0;
        out_last_r <= (ch_r == CH_LAST);
      end else begin
        out_cmd_r  <= cmd_r;
        out_per_r  <= (cmd_r == frtt_pkg::CMD_OFF) ? '0 : per_r;
        out_vol_r  <= (cmd_r == frtt_pkg::CMD_OFF) ? '0 : vol_r;
        out_last_r <= 1'b1;
      end
    end
  end

  // Drive the channels
  assign in_ch.ready    = in_ready;
  assign cfg_ch.ready   = 1'b1;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.command = out_cmd_r;
  assign out_ch.channel = out_ch_r;
  assign out_ch.period  = out_per_r;
  assign out_ch.volume  = out_vol_r;
  assign out_ch.last    = out_last_r;

endmodule

`default_nettype wire

// ===== tb/frtt_tone_checker.sv =====
// frtt_tone_checker: watches the register, command and tone clock channels of
// the FM register to tone translator, predicts every tone command and compares.
// Depends on frtt_pkg and frtt_if.
`timescale 1ns / 1ps

module frtt_tone_checker
  import frtt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  frtt_in_if   in_mon,
  frtt_out_if  out_mon,
  frtt_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending,
  output int   checked_count
);

  typedef struct packed {
    cmd_t             command;
    logic [CH_W-1:0]  channel;
    logic [PER_W-1:0] period;
    logic [VOL_W-1:0] volume;
    logic             last;
  } tone_cmd_t;

  // Shadow copies of the block's per-channel registers and the tone clock
  logic [VAL_W-1:0] fnum_low      [CHANNELS];
  logic [VAL_W-1:0] fnum_high     [CHANNELS];
  logic [LVL_W-1:0] carrier_level [CHANNELS];
  logic [TC_W-1:0]  tone_clock;

  tone_cmd_t tone_cmds_q[$];
  int        mismatches = 0;
  int        results_seen = 0;

  // Period from F-number and block: clock over pitch, saturated; 0 when pitch < 2
  function automatic logic [PER_W-1:0] tone_period(logic [FNUM_W-1:0] fnum,
                                                   logic [BLK_W-1:0] block);
    logic [31:0] pitch;
    logic [31:0] quot;
    pitch = (32'(fnum) * 32'(FM_CONST)) >> (32'(SHIFT_BASE) - 32'(block));
    if (pitch < 32'd2) return '0;
    quot = 32'(tone_clock) / pitch;
    return (quot > 32'(PERIOD_MAX)) ? PERIOD_MAX : quot[PER_W-1:0];
  endfunction

  function automatic tone_cmd_t evaluate_channel(int ch, logic [MASK_W-1:0] mask);
    logic [VOL_W-1:0] vol;
    logic [PER_W-1:0] per;
    tone_cmd_t        cmd;
    vol = VOL_FULL - VOL_W'(carrier_level[ch] >> 2);
    cmd = '{command: CMD_OFF, channel: CH_W'(ch), period: '0, volume: '0, last: 1'b1};
    if (fnum_high[ch][KEYON_POS] && vol != '0) begin
      per = tone_period({fnum_high[ch][1:0], fnum_low[ch]}, fnum_high[ch][4:2]);
      if (per != '0) begin
        if (mask[ch]) cmd.command = CMD_SET;
        else cmd.command = CMD_ON;
        cmd.period = per;
        cmd.volume = vol;
      end
    end
    return cmd;
  endfunction

  function automatic bit in_sync(int ch, logic [MASK_W-1:0] mask);
    return mask[ch] == fnum_high[ch][KEYON_POS];
  endfunction

  task automatic clear_shadows();
    for (int i = 0; i < CHANNELS; i++) begin
      fnum_low[i] = '0;
      fnum_high[i] = '0;
      carrier_level[i] = '0;
    end
  endtask

  // Update the shadows for one register transaction and queue its commands
  task automatic predict_tone_cmds(logic mode, logic [ADDR_W-1:0] addr,
                                   logic [VAL_W-1:0] value, logic [MASK_W-1:0] mask);
    int               ch;
    int               op;
    int               col;
    logic [LVL_W-1:0] lv;
    if (mode) begin
      clear_shadows();
      for (int i = 0; i < CHANNELS; i++)
        tone_cmds_q.push_back('{command: CMD_OFF, channel: CH_W'(i), period: '0,
                                volume: '0, last: (i == CHANNELS - 1)});
      return;
    end
    if (addr >= ADDR_FLO && addr < ADDR_FLO + CHANNELS) begin
      ch = int'(addr - ADDR_FLO);
      if (fnum_low[ch] == value && in_sync(ch, mask)) return;
      fnum_low[ch] = value;
      if (fnum_high[ch][KEYON_POS]) tone_cmds_q.push_back(evaluate_channel(ch, mask));
    end else if (addr >= ADDR_FHI && addr < ADDR_FHI + CHANNELS) begin
      ch = int'(addr - ADDR_FHI);
      if (fnum_high[ch] == value && in_sync(ch, mask)) return;
      fnum_high[ch] = value;
      tone_cmds_q.push_back(evaluate_channel(ch, mask));
    end else if (addr >= ADDR_LEVEL && addr < ADDR_LEVEL + LEVEL_SPAN) begin
      op = int'(addr - ADDR_LEVEL);
      col = op % 8;
      // only the carrier columns carry a channel level
      if (col < 3 || col > 5) return;
      ch = (op / 8) * 3 + col - 3;
      if (ch >= CHANNELS) return;
      lv = value[LVL_W-1:0] & LEVEL_MASK;
      if (carrier_level[ch] == lv && in_sync(ch, mask)) return;
      carrier_level[ch] = lv;
      if (fnum_high[ch][KEYON_POS]) tone_cmds_q.push_back(evaluate_channel(ch, mask));
    end
  endtask

  function automatic bit field_differs(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Compare commands first, so a transaction taken at the same edge queues behind them
  always @(posedge clk) begin : watch
    tone_cmd_t want;
    bit        bad;
    if (!rst_n) begin
      clear_shadows();
      tone_clock = TONE_CLOCK_RST;
      tone_cmds_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) tone_clock = cfg_mon.tone_clock;
      if (out_mon.valid && out_mon.ready) begin
        results_seen++;
        if (tone_cmds_q.size() == 0) begin
          $display("%0t: unexpected command %0d on channel %0d, nothing awaited",
                   $time, out_mon.command, out_mon.channel);
          mismatches++;
        end else begin
          want = tone_cmds_q.pop_front();
          bad = field_differs("command", want.command, out_mon.command);
          bad |= field_differs("channel", want.channel, out_mon.channel);
          bad |= field_differs("period", want.period, out_mon.period);
          bad |= field_differs("volume", want.volume, out_mon.volume);
          bad |= field_differs("last", want.last, out_mon.last);
          if (bad) mismatches++;
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_tone_cmds(in_mon.mode, in_mon.reg_address, in_mon.reg_value,
                          in_mon.tone_active_mask);
    end
    fail_count <= mismatches;
    pending <= tone_cmds_q.size();
    checked_count <= results_seen;
  end

endmodule

// ===== tb/tb_fm_register_to_tone_translator_unit.sv =====
// tb_fm_register_to_tone_translator_unit: drives register and tone clock
// transactions with random idling and gives the verdict. Depends on frtt_pkg,
// frtt_if, frtt_tone_checker and the fm_register_to_tone_translator_unit RTL.
`timescale 1ns / 1ps

module tb_fm_register_to_tone_translator_unit;
  import frtt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int ITEMS_PER_PHASE = 34;
  localparam int PHASES = 6;
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  logic clk;
  logic rst_n;

  frtt_in_if  in_ch();
  frtt_out_if out_ch();
  frtt_cfg_if cfg_ch();

  int fail_count;
  int pending;
  int checked_count;
  int cycle_count = 0;
  int stall_left = 0;
  int items_sent = 0;
  int clock_writes = 0;
  bit steady_flow = 1'b0;
  bit keyon_seen [CHANNELS];
  logic [ADDR_W-1:0] prev_addr = '0;
  logic [VAL_W-1:0]  prev_value = '0;

  fm_register_to_tone_translator_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  frtt_tone_checker u_tone_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_mon       (cfg_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the command side in bursts of random length
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!steady_flow && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d commands still awaited", cycle_count, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one register transaction, possibly after an idle burst, and hold it until taken
  task automatic send_item(logic mode, logic [ADDR_W-1:0] addr, logic [VAL_W-1:0] value,
                           logic [MASK_W-1:0] mask);
    if (!steady_flow && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.reg_address <= addr;
    in_ch.reg_value <= value;
    in_ch.tone_active_mask <= mask;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    // track key-on so the active mask often agrees with it
    if (mode) begin
      foreach (keyon_seen[i]) keyon_seen[i] = 1'b0;
    end else if (addr >= ADDR_FHI && addr < ADDR_FHI + CHANNELS) begin
      keyon_seen[addr - ADDR_FHI] = value[KEYON_POS];
    end
    prev_addr = addr;
    prev_value = value;
  endtask

  // Drain every command, let the block settle, then write the tone clock
  task automatic set_tone_clock(logic [TC_W-1:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.tone_clock <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    clock_writes++;
  endtask

  // Half the time a mask that follows key-on, with an occasional slot out of step
  function automatic logic [MASK_W-1:0] pick_mask();
    logic [MASK_W-1:0] m;
    m = MASK_W'($urandom);
    if ($urandom_range(0, 1) == 1) begin
      foreach (keyon_seen[i]) m[i] = keyon_seen[i];
      if ($urandom_range(0, 3) == 0) m[$urandom_range(0, MASK_W - 1)] ^= 1'b1;
    end
    return m;
  endfunction

  task automatic run_random(int count);
    int                done;
    int                pick;
    logic              mode;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  value;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      mode = MODE_WRITE;
      value = VAL_W'($urandom);
      addr = ADDR_W'($urandom);
      if (pick < 3) begin
        mode = MODE_CLEAR;
      end else if (pick < 20) begin
        // repeat the last write to reach the drop paths
        addr = prev_addr;
        value = prev_value;
      end else if (pick < 45) begin
        addr = ADDR_FHI + ADDR_W'($urandom_range(0, CHANNELS - 1));
        if ($urandom_range(0, 3) != 0) value[KEYON_POS] = 1'b1;
      end else if (pick < 65) begin
        addr = ADDR_FLO + ADDR_W'($urandom_range(0, CHANNELS - 1));
      end else if (pick < 88) begin
        addr = ADDR_LEVEL + ADDR_W'($urandom_range(0, int'(LEVEL_SPAN) - 1));
      end
      send_item(mode, addr, value, pick_mask());
      done++;
    end
  endtask

  initial begin
    logic [TC_W-1:0] clock_plan [PHASES];
    foreach (keyon_seen[i]) keyon_seen[i] = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_WRITE;
    in_ch.reg_address <= '0;
    in_ch.reg_value <= '0;
    in_ch.tone_active_mask <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.tone_clock <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: clear, key-on flow on channel 0, pitch and level extremes
    send_item(MODE_CLEAR, 8'h00, 8'h00, 9'h000);
    send_item(MODE_WRITE, ADDR_LEVEL + 8'h03, 8'hC0, 9'h001);
    send_item(MODE_WRITE, ADDR_FLO, 8'h41, 9'h000);
    send_item(MODE_WRITE, ADDR_FHI, 8'h31, 9'h000);
    send_item(MODE_WRITE, ADDR_FHI, 8'h31, 9'h001);
    send_item(MODE_WRITE, ADDR_FHI, 8'h31, 9'h000);
    send_item(MODE_WRITE, ADDR_FLO, 8'hFF, 9'h001);
    send_item(MODE_WRITE, ADDR_FHI, 8'h3F, 9'h001);
    send_item(MODE_WRITE, ADDR_FHI, 8'h23, 9'h001);
    send_item(MODE_WRITE, ADDR_FHI, 8'h20, 9'h001);
    send_item(MODE_WRITE, ADDR_FLO, 8'd42, 9'h001);
    send_item(MODE_WRITE, ADDR_FLO, 8'd43, 9'h001);
    send_item(MODE_WRITE, ADDR_LEVEL + 8'h03, 8'h3C, 9'h001);
    send_item(MODE_WRITE, ADDR_LEVEL + 8'h03, 8'h3B, 9'h001);
    send_item(MODE_WRITE, ADDR_FLO, 8'h00, 9'h001);
    send_item(MODE_WRITE, ADDR_FHI, 8'h1F, 9'h001);
    // channel 8 through its carrier at the top of the level range
    send_item(MODE_WRITE, ADDR_FHI + 8'd8, 8'h2A, 9'h000);
    send_item(MODE_WRITE, ADDR_LEVEL + 8'h15, 8'h10, 9'h100);
    // modulator columns and unmapped addresses
    send_item(MODE_WRITE, ADDR_LEVEL, 8'h00, 9'h000);
    send_item(MODE_WRITE, ADDR_LEVEL + 8'h06, 8'h15, 9'h1FF);
    send_item(MODE_WRITE, ADDR_FLO + 8'd9, 8'h77, 9'h000);
    send_item(MODE_WRITE, ADDR_FHI + 8'd9, 8'h3F, 9'h000);
    send_item(MODE_WRITE, 8'hFF, 8'hFF, 9'h000);
    // largest tone clock saturates the period; smallest drives it to zero
    set_tone_clock(20'hFFFFF);
    send_item(MODE_WRITE, ADDR_FHI + 8'd8, 8'h2A, 9'h000);
    send_item(MODE_WRITE, ADDR_FHI + 8'd8, 8'h3F, 9'h100);
    set_tone_clock(20'd1);
    send_item(MODE_WRITE, ADDR_FHI + 8'd8, 8'h3A, 9'h100);
    send_item(MODE_CLEAR, 8'hFF, 8'hFF, 9'h1FF);

    // Random phases over a spread of tone clocks; the last one runs without idling
    clock_plan[0] = TONE_CLOCK_RST;
    clock_plan[1] = 20'hFFFFF;
    clock_plan[2] = 20'd1;
    clock_plan[3] = TC_W'($urandom_range(2, 4000));
    clock_plan[4] = TC_W'($urandom_range(4001, 20'hFFFFF));
    clock_plan[5] = TONE_CLOCK_RST;
    for (int p = 0; p < PHASES; p++) begin
      set_tone_clock(clock_plan[p]);
      if (p == PHASES - 1) steady_flow = 1'b1;
      run_random(ITEMS_PER_PHASE);
    end

    // Wait out the remaining commands
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d register transactions across %0d tone clock writes,", items_sent,
             clock_writes);
    $display("checked %0d tone commands, %0d failures.", checked_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
